// ----- design/stlm_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the two-list merge core.
package stlm_pkg;

    // Element storage geometry
    localparam int LIST_DEPTH    = 32;
    localparam int ELEMENT_WIDTH = 32;
    localparam int VALUE_W       = 32;
    localparam int CMD_W         = 2;
    localparam int CNT_W         = $clog2(LIST_DEPTH + 1);
    localparam int ADDR_W        = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    // Input item commands
    localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MERGE  = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_MERGE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic emit;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic a_done;
        logic b_done;
        logic last;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- design/sorted_two_list_merge_core.sv -----
// Top level of the two-list merge core: controller, datapath and checks.
//
// Load items (cmd 0 or 1) append a word to the first or second list; a load into a
// full list is dropped and flagged on the next merge. A merge item (cmd 2) streams
// every stored word in ascending order at one result per cycle while the output is
// taken, ties going to the second list, the final result marked by is_last; the
// merge then empties both lists. No new item is accepted until the merge has issued
// its last result, or has found both lists empty. The pace is set by the single
// read port of each list memory, which is read at its head pointer. The finished
// result sits in an output register, so a following load can be accepted while it
// waits.
module sorted_two_list_merge_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [stlm_pkg::CMD_W-1:0]   i_cmd,
    input  logic [stlm_pkg::VALUE_W-1:0] i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [stlm_pkg::VALUE_W-1:0] o_merged_value,
    output logic                         o_is_last,
    output logic                         o_lost_any
);

    stlm_pkg::t_dp_cmd  dp_cmd;
    stlm_pkg::t_dp_stat dp_stat;
    stlm_pkg::t_state   state;

    stlm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_dp_stat  (dp_stat),
        .o_in_ready (o_in_ready),
        .o_dp_cmd   (dp_cmd),
        .o_state    (state)
    );

    stlm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_dp_cmd       (dp_cmd),
        .o_dp_stat      (dp_stat),
        .i_value        (i_value),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_merged_value (o_merged_value),
        .o_is_last      (o_is_last),
        .o_lost_any     (o_lost_any)
    );

    // Never emit past the end of both lists
    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.emit |-> !(dp_stat.a_done && dp_stat.b_done))
        else $error("emit with both lists used up");

    // Loads and emits never overlap
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({dp_cmd.load_a, dp_cmd.load_b, dp_cmd.emit}))
        else $error("conflicting datapath commands");

    // No emit while idle
    a_emit_in_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.emit |-> (state == stlm_pkg::ST_MERGE))
        else $error("emit outside merge");

    // Within one merge, the stream continues with the same drop flag
    a_stream_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_is_last)
        |=> (o_out_valid && (o_lost_any == $past(o_lost_any))))
        else $error("merge stream broken or drop flag changed");

endmodule

// ----- design/stlm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module stlm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/stlm_dp.sv -----
// Datapath: list storage, fill counts, merge pointers, head compare and output register.
module stlm_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  stlm_pkg::t_dp_cmd              i_dp_cmd,
    output stlm_pkg::t_dp_stat             o_dp_stat,
    input  logic [stlm_pkg::VALUE_W-1:0]   i_value,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [stlm_pkg::VALUE_W-1:0]   o_merged_value,
    output logic                           o_is_last,
    output logic                           o_lost_any
);

    logic [stlm_pkg::CNT_W-1:0]         r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [stlm_pkg::CNT_W-1:0]         r_ptr_a, n_ptr_a, r_ptr_b, n_ptr_b;
    logic                               r_ovf, n_ovf;
    logic                               r_out_valid, n_out_valid;
    logic [stlm_pkg::VALUE_W-1:0]       r_out_value;
    logic                               r_out_last, r_out_lost;
    logic [stlm_pkg::ELEMENT_WIDTH-1:0] wdata;
    logic [stlm_pkg::ELEMENT_WIDTH-1:0] rd_a, rd_b, pick;
    logic                               full_a, full_b, we_a, we_b;
    logic                               a_done, b_done, take_a;
    logic                               a_done_after, b_done_after;

    assign wdata  = i_value[stlm_pkg::ELEMENT_WIDTH-1:0];
    assign full_a = (r_cnt_a == stlm_pkg::CNT_W'(stlm_pkg::LIST_DEPTH));
    assign full_b = (r_cnt_b == stlm_pkg::CNT_W'(stlm_pkg::LIST_DEPTH));
    assign we_a   = i_dp_cmd.load_a && !full_a;
    assign we_b   = i_dp_cmd.load_b && !full_b;

    // Head compare: second list wins ties
    assign a_done = (r_ptr_a == r_cnt_a);
    assign b_done = (r_ptr_b == r_cnt_b);
    assign take_a = !a_done && (b_done || (rd_a < rd_b));
    assign pick   = take_a ? rd_a : rd_b;

    // Last element when both lists are used up after this step
    assign a_done_after = take_a ? (stlm_pkg::CNT_W'(r_ptr_a + 1'b1) == r_cnt_a) : a_done;
    assign b_done_after = take_a ? b_done : (stlm_pkg::CNT_W'(r_ptr_b + 1'b1) == r_cnt_b);

    assign o_dp_stat.a_done   = a_done;
    assign o_dp_stat.b_done   = b_done;
    assign o_dp_stat.last     = a_done_after && b_done_after;
    assign o_dp_stat.out_free = !r_out_valid || i_out_ready;

    // Next state of counts, pointers and drop flag
    always_comb begin
        n_cnt_a = r_cnt_a;
        n_cnt_b = r_cnt_b;
        n_ptr_a = r_ptr_a;
        n_ptr_b = r_ptr_b;
        n_ovf   = r_ovf;
        if (we_a) begin
            n_cnt_a = stlm_pkg::CNT_W'(r_cnt_a + 1'b1);
        end
        if (we_b) begin
            n_cnt_b = stlm_pkg::CNT_W'(r_cnt_b + 1'b1);
        end
        if ((i_dp_cmd.load_a && full_a) || (i_dp_cmd.load_b && full_b)) begin
            n_ovf = 1'b1;
        end
        if (i_dp_cmd.emit) begin
            if (take_a) begin
                n_ptr_a = stlm_pkg::CNT_W'(r_ptr_a + 1'b1);
            end else begin
                n_ptr_b = stlm_pkg::CNT_W'(r_ptr_b + 1'b1);
            end
        end
        if (i_dp_cmd.finish) begin
            n_cnt_a = '0;
            n_cnt_b = '0;
            n_ptr_a = '0;
            n_ptr_b = '0;
            n_ovf   = 1'b0;
        end
    end

    // Output register: load on emit, drop once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_dp_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_ptr_a     <= '0;
            r_ptr_b     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_ptr_a     <= n_ptr_a;
            r_ptr_b     <= n_ptr_b;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold result payload
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.emit) begin
            r_out_value <= stlm_pkg::VALUE_W'(pick);
            r_out_last  <= a_done_after && b_done_after;
            r_out_lost  <= r_ovf;
        end
    end

    // List storage; read address follows the next head pointer
    stlm_ram #(
        .WIDTH (stlm_pkg::ELEMENT_WIDTH),
        .DEPTH (stlm_pkg::LIST_DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[stlm_pkg::ADDR_W-1:0]),
        .i_wdata (wdata),
        .i_raddr (n_ptr_a[stlm_pkg::ADDR_W-1:0]),
        .o_rdata (rd_a)
    );

    stlm_ram #(
        .WIDTH (stlm_pkg::ELEMENT_WIDTH),
        .DEPTH (stlm_pkg::LIST_DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[stlm_pkg::ADDR_W-1:0]),
        .i_wdata (wdata),
        .i_raddr (n_ptr_b[stlm_pkg::ADDR_W-1:0]),
        .o_rdata (rd_b)
    );

    assign o_out_valid    = r_out_valid;
    assign o_merged_value = r_out_value;
    assign o_is_last      = r_out_last;
    assign o_lost_any     = r_out_lost;

endmodule

// ----- design/stlm_ctrl.sv -----
// Controller: accepts items while idle and sequences the merge stream.
module stlm_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [stlm_pkg::CMD_W-1:0]   i_cmd,
    input  stlm_pkg::t_dp_stat           i_dp_stat,
    output logic                         o_in_ready,
    output stlm_pkg::t_dp_cmd            o_dp_cmd,
    output stlm_pkg::t_state             o_state
);

    stlm_pkg::t_state r_state, n_state;
    logic             accept;
    logic             can_emit;

    assign accept   = i_in_valid && (r_state == stlm_pkg::ST_IDLE);
    assign can_emit = i_dp_stat.out_free && !(i_dp_stat.a_done && i_dp_stat.b_done);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stlm_pkg::ST_IDLE: begin
                if (accept && (i_cmd == stlm_pkg::CMD_MERGE)) begin
                    n_state = stlm_pkg::ST_MERGE;
                end
            end
            stlm_pkg::ST_MERGE: begin
                if ((i_dp_stat.a_done && i_dp_stat.b_done) || (can_emit && i_dp_stat.last)) begin
                    n_state = stlm_pkg::ST_IDLE;
                end
            end
            default: n_state = stlm_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_dp_cmd   = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            stlm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    unique case (i_cmd)
                        stlm_pkg::CMD_LOAD_A: o_dp_cmd.load_a = 1'b1;
                        stlm_pkg::CMD_LOAD_B: o_dp_cmd.load_b = 1'b1;
                        default: ;
                    endcase
                end
            end
            stlm_pkg::ST_MERGE: begin
                o_dp_cmd.emit   = can_emit;
                o_dp_cmd.finish = (i_dp_stat.a_done && i_dp_stat.b_done)
                                  || (can_emit && i_dp_stat.last);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stlm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule
